### rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int ATTR_W  = 2 * COLOR_W;
  localparam int POS_W   = 11;

  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [COLOR_W-1:0] BG_RESET     = 4'd0;
  localparam logic [COLOR_W-1:0] FG_RESET     = 4'd7;

  localparam logic CFG_BACKGROUND = 1'b0;
  localparam logic CFG_FOREGROUND = 1'b1;

  typedef enum logic [1:0] {
    KIND_PRINT = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attribute;
    logic              scrolled;
  } res_t;

endpackage

`default_nettype wire

### rtl/tcw_store.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_store #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [tcw_pkg::CHAR_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [tcw_pkg::CHAR_W-1:0] rdata_o
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 kind_i,
  input  logic [7:0]                 char_code_i,
  input  logic [4:0]                 read_row_i,
  input  logic [6:0]                 read_column_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attr_i,
  input  logic                       out_free_i,
  output logic                       res_valid_o,
  output tcw_pkg::res_t              res_o
);
  import tcw_pkg::*;

  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = $clog2(DEPTH + 1);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int BOTTOM = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_FILL,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic cp_v_q, cp_v_d;
  logic [AW-1:0] cp_wa_q, cp_wa_d;
  logic emit_q, emit_d;
  logic scr_q, scr_d;
  logic hit_q, hit_d;
  logic [CHAR_W-1:0] cchar_q, cchar_d;
  logic [ATTR_W-1:0] cattr_q, cattr_d;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic mem_re;
  logic [AW-1:0] mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  logic [31:0] rd_lin;
  logic [31:0] pos_full;
  logic rd_in_range;
  logic accept;
  logic last_col;
  logic last_row;
  kind_e kind;

  tcw_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign kind        = kind_e'(kind_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign rd_lin      = 32'(read_row_i) * 32'(COLUMNS) + 32'(read_column_i);
  assign rd_in_range = (32'(read_row_i) < 32'(ROWS)) && (32'(read_column_i) < 32'(COLUMNS));
  assign last_col    = (col_q == CW'(COLUMNS - 1));
  assign last_row    = (row_q == RW'(ROWS - 1));
  assign pos_full    = 32'(cur_q);

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    cur_d       = cur_q;
    ptr_d       = ptr_q;
    cp_v_d      = 1'b0;
    cp_wa_d     = cp_wa_q;
    emit_d      = emit_q;
    scr_d       = scr_q;
    hit_d       = hit_q;
    cchar_d     = cchar_q;
    cattr_d     = cattr_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = char_code_i;
    mem_re      = 1'b0;
    mem_raddr   = rd_lin[AW-1:0];
    res_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          emit_d  = 1'b1;
          scr_d   = 1'b0;
          cchar_d = '0;
          cattr_d = '0;
          state_d = S_DONE;
          unique case (kind)
            KIND_PRINT: begin
              if (char_code_i != NEWLINE_CODE) begin
                mem_we = 1'b1;
              end
              if ((char_code_i == NEWLINE_CODE) || last_col) begin
                col_d = '0;
                if (last_row) begin
                  scr_d   = 1'b1;
                  cur_d   = AW'(BOTTOM);
                  ptr_d   = PW'(COLUMNS);
                  state_d = S_COPY;
                end else begin
                  row_d = row_q + 1'b1;
                  cur_d = cur_q + AW'(COLUMNS) - AW'(col_q);
                end
              end else begin
                col_d = col_q + 1'b1;
                cur_d = cur_q + 1'b1;
              end
            end
            KIND_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              cur_d   = '0;
              ptr_d   = '0;
              state_d = S_FILL;
            end
            KIND_READ: begin
              mem_re  = 1'b1;
              hit_d   = rd_in_range;
              state_d = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (hit_q) begin
          cchar_d = mem_rdata;
          cattr_d = attr_i;
        end
        state_d = S_DONE;
      end
      S_COPY: begin
        if (cp_v_q) begin
          mem_we    = 1'b1;
          mem_waddr = cp_wa_q;
          mem_wdata = mem_rdata;
        end
        if (ptr_q == PW'(DEPTH)) begin
          ptr_d   = PW'(BOTTOM);
          state_d = S_FILL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[AW-1:0];
          cp_v_d    = 1'b1;
          cp_wa_d   = ptr_q[AW-1:0] - AW'(COLUMNS);
          ptr_d     = ptr_q + 1'b1;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AW-1:0];
        mem_wdata = SPACE_CODE;
        if (ptr_q == PW'(DEPTH - 1)) begin
          state_d = emit_q ? S_DONE : S_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
      row_q   <= '0;
      col_q   <= '0;
      cur_q   <= '0;
      ptr_q   <= '0;
      cp_v_q  <= 1'b0;
      cp_wa_q <= '0;
      emit_q  <= 1'b0;
      scr_q   <= 1'b0;
      hit_q   <= 1'b0;
      cchar_q <= '0;
      cattr_q <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      cur_q   <= cur_d;
      ptr_q   <= ptr_d;
      cp_v_q  <= cp_v_d;
      cp_wa_q <= cp_wa_d;
      emit_q  <= emit_d;
      scr_q   <= scr_d;
      hit_q   <= hit_d;
      cchar_q <= cchar_d;
      cattr_q <= cattr_d;
    end
  end

  always_comb begin
    res_o.cursor_position = pos_full[POS_W-1:0];
    res_o.cell_char       = cchar_q;
    res_o.cell_attribute  = cattr_q;
    res_o.scrolled        = scr_q;
  end

endmodule

`default_nettype wire

### rtl/text_console_writer_core.sv
// A print, a newline or an unused kind goes straight to its result, a read first fetches
// the cell; no new request is taken until the last result has passed to the output. A
// scroll copies the screen up through the one-read, one-write character memory at one
// cell a cycle and blanks the bottom row; a clear blanks every cell. After reset the
// memory is swept to spaces before the first request is taken; colors reset to
// background 0, foreground 7.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] char_code_i,
  input  logic [4:0] read_row_i,
  input  logic [6:0] read_column_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [10:0] cursor_position_o,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_attribute_o,
  output logic       scrolled_o
);
  import tcw_pkg::*;

  localparam logic [POS_W-1:0] BOTTOM_POS = POS_W'((ROWS - 1) * COLUMNS);

  logic [COLOR_W-1:0] bg_q, bg_d;
  logic [COLOR_W-1:0] fg_q, fg_d;
  logic out_valid_q, out_valid_d;
  res_t out_q, out_d;
  res_t res;
  logic res_valid;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  tcw_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_column_i(read_column_i),
    .attr_i       ({bg_q, fg_q}),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_comb begin
    bg_d = bg_q;
    fg_d = fg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_BACKGROUND: bg_d = cfg_wdata_i;
        CFG_FOREGROUND: fg_d = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q        <= BG_RESET;
      fg_q        <= FG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      bg_q        <= bg_d;
      fg_q        <= fg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = out_q.cursor_position;
  assign cell_char_o       = out_q.cell_char;
  assign cell_attribute_o  = out_q.cell_attribute;
  assign scrolled_o        = out_q.scrolled;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while the previous one was still in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || out_ready_i))
    else $error("result pushed over an untaken result");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && scrolled_o) |-> (cursor_position_o == BOTTOM_POS))
    else $error("scroll did not leave the cursor at the start of the bottom row");
`endif

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = ROWS * COLUMNS;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int CYCLE_LIMIT = 30_000_000;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  class console_screen;
    logic [CHAR_W-1:0]  screen [CELLS];
    int unsigned        cur_row;
    int unsigned        cur_col;
    logic [COLOR_W-1:0] background;
    logic [COLOR_W-1:0] foreground;
    res_t               due_results [$];
    int                 errors;

    function new();
      blank_screen();
      cur_row    = 0;
      cur_col    = 0;
      background = BG_RESET;
      foreground = FG_RESET;
      errors     = 0;
    endfunction

    function void blank_screen();
      foreach (screen[i]) screen[i] = SPACE_CODE;
    endfunction

    // Returns 1 when the move to the next row scrolled the screen.
    function bit next_row();
      bit moved_up;
      moved_up = 1'b0;
      if (cur_row + 1 >= ROWS) begin
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen[i] = SPACE_CODE;
        cur_row  = ROWS - 1;
        moved_up = 1'b1;
      end else begin
        cur_row++;
      end
      cur_col = 0;
      return moved_up;
    endfunction

    function void set_color(logic addr, logic [COLOR_W-1:0] value);
      if (addr == CFG_BACKGROUND) begin
        background = value;
      end else begin
        foreground = value;
      end
    endfunction

    function void note_request(logic [1:0] kind, logic [CHAR_W-1:0] code,
                               logic [4:0] rrow, logic [6:0] rcol);
      res_t exp;
      exp = '0;
      case (kind)
        KIND_PRINT: begin
          if (code == NEWLINE_CODE) begin
            exp.scrolled = next_row();
          end else begin
            screen[cur_row * COLUMNS + cur_col] = code;
            cur_col++;
            if (cur_col >= COLUMNS) exp.scrolled = next_row();
          end
        end
        KIND_CLEAR: begin
          blank_screen();
          cur_row = 0;
          cur_col = 0;
        end
        KIND_READ: begin
          if (rrow < ROWS && rcol < COLUMNS) begin
            exp.cell_char      = screen[rrow * COLUMNS + rcol];
            exp.cell_attribute = {background, foreground};
          end
        end
        default: begin
        end
      endcase
      exp.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
      due_results.push_back(exp);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(res_t got);
      res_t exp;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        exp = due_results.pop_front();
        if (got.cursor_position !== exp.cursor_position)
          report($sformatf("cursor_position %0d, expected %0d",
                           got.cursor_position, exp.cursor_position));
        if (got.cell_char !== exp.cell_char)
          report($sformatf("cell_char %h, expected %h", got.cell_char, exp.cell_char));
        if (got.cell_attribute !== exp.cell_attribute)
          report($sformatf("cell_attribute %h, expected %h",
                           got.cell_attribute, exp.cell_attribute));
        if (got.scrolled !== exp.scrolled)
          report($sformatf("scrolled %b, expected %b", got.scrolled, exp.scrolled));
      end
    endtask

    task flush_missing();
      while (due_results.size() != 0) begin
        report($sformatf("result never came: %h", due_results.pop_front()));
      end
    endtask

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_addr_i    = CFG_BACKGROUND;
  logic [3:0]        cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [1:0]        kind_i        = KIND_PRINT;
  logic [7:0]        char_code_i   = '0;
  logic [4:0]        read_row_i    = '0;
  logic [6:0]        read_column_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [POS_W-1:0]  cursor_position_o;
  logic [7:0]        cell_char_o;
  logic [7:0]        cell_attribute_o;
  logic              scrolled_o;

  console_screen screen_state = new();
  int            item_count   = 0;
  int            idle_pct     = 0;
  int            stall_pct    = 0;
  int            long_hold    = 0;
  int            cycle_count  = 0;

  text_console_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .char_code_i      (char_code_i),
    .read_row_i       (read_row_i),
    .read_column_i    (read_column_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cursor_position_o(cursor_position_o),
    .cell_char_o      (cell_char_o),
    .cell_attribute_o (cell_attribute_o),
    .scrolled_o       (scrolled_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      screen_state.check_result('{cursor_position_o, cell_char_o, cell_attribute_o,
                                  scrolled_o});
    end
    if (long_hold > 0) begin
      long_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic push_request(logic [1:0] kind, logic [7:0] code, logic [4:0] rrow,
                              logic [6:0] rcol);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    char_code_i   <= code;
    read_row_i    <= rrow;
    read_column_i <= rcol;
    do @(posedge clk_i); while (!in_ready_o);
    screen_state.note_request(kind, code, rrow, rcol);
    item_count++;
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (screen_state.pending() != 0);
  endtask

  task automatic set_colors(logic [3:0] bg, logic [3:0] fg);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_BACKGROUND;
    cfg_wdata_i <= bg;
    @(posedge clk_i);
    screen_state.set_color(CFG_BACKGROUND, bg);
    cfg_addr_i  <= CFG_FOREGROUND;
    cfg_wdata_i <= fg;
    @(posedge clk_i);
    screen_state.set_color(CFG_FOREGROUND, fg);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_traffic(int count);
    int         start;
    int         seg;
    int         len;
    int         pick;
    int         nl_pct;
    bit         paused;
    logic [7:0] code;
    logic [4:0] rrow;
    logic [6:0] rcol;
    start  = item_count;
    paused = 1'b0;
    while (item_count - start < count) begin
      if (!paused && item_count - start >= count / 2) begin
        wait_all_results();
        paused = 1'b1;
      end
      seg = $urandom_range(0, 99);
      if (seg < 60) begin
        len    = $urandom_range(10, 60);
        nl_pct = $urandom_range(0, 1) ? 12 : 0;
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) begin
            code = ($urandom_range(0, 99) < nl_pct) ? NEWLINE_CODE : 8'($urandom);
            push_request(KIND_PRINT, code, 5'($urandom), 7'($urandom));
          end else if (pick < 95) begin
            rrow = ($urandom_range(0, 1)) ? 5'(screen_state.cur_row)
                                          : 5'($urandom_range(0, ROWS - 1));
            rcol = 7'($urandom_range(0, COLUMNS - 1));
            push_request(KIND_READ, 8'($urandom), rrow, rcol);
          end else if (pick < 98) begin
            push_request(KIND_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
          end else begin
            push_request(KIND_READ, 8'($urandom), 5'($urandom_range(ROWS, 31)),
                         7'($urandom));
          end
        end
      end else if (seg < 80) begin
        len = $urandom_range(3, 26);
        repeat (len) push_request(KIND_PRINT, NEWLINE_CODE, 5'($urandom), 7'($urandom));
        push_request(KIND_READ, 8'($urandom), 5'(ROWS - 1),
                     7'($urandom_range(0, COLUMNS - 1)));
      end else if (seg < 96) begin
        len = $urandom_range(10, 40);
        repeat (len) begin
          pick = $urandom_range(0, 99);
          rrow = 5'($urandom_range(0, ROWS - 1));
          rcol = 7'($urandom_range(0, COLUMNS - 1));
          if (pick < 6) rrow = 5'($urandom_range(ROWS, 31));
          else if (pick < 12) rcol = 7'($urandom_range(COLUMNS, 127));
          push_request(KIND_READ, 8'($urandom), rrow, rcol);
        end
      end else begin
        push_request(KIND_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
        push_request(KIND_READ, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
                     7'($urandom_range(0, COLUMNS - 1)));
      end
    end
  endtask

  initial begin
    logic [3:0] bg;
    logic [3:0] fg;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Colors stay at their reset values for the opening requests.
    push_request(KIND_READ, 8'd0, 5'd0, 7'd0);
    push_request(KIND_READ, 8'd0, 5'(ROWS - 1), 7'(COLUMNS - 1));
    push_request(KIND_READ, 8'd0, 5'(ROWS), 7'd0);
    push_request(KIND_READ, 8'd0, 5'd0, 7'(COLUMNS));
    push_request(KIND_READ, 8'hFF, 5'h1F, 7'h7F);
    push_request(KIND_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    push_request(KIND_PRINT, 8'h00, 5'h1F, 7'h7F);
    push_request(KIND_PRINT, 8'hFF, 5'd0, 7'd0);
    push_request(KIND_PRINT, 8'h41, 5'd0, 7'd0);
    push_request(KIND_READ, NEWLINE_CODE, 5'd0, 7'd2);
    push_request(KIND_PRINT, NEWLINE_CODE, 5'h1F, 7'h7F);
    push_request(KIND_READ, 8'd0, 5'd0, 7'd0);
    push_request(KIND_READ, 8'd0, 5'd0, 7'd1);
    push_request(KIND_PRINT, SPACE_CODE, 5'd0, 7'd0);
    push_request(KIND_CLEAR, NEWLINE_CODE, 5'h1F, 7'h7F);
    push_request(KIND_READ, 8'd0, 5'd0, 7'd1);
    push_request(KIND_READ, 8'd0, 5'd1, 7'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      if (phase > 0) begin
        wait_all_results();
        repeat (CELLS + 10) @(posedge clk_i);
        case (phase)
          1: begin bg = 4'hF; fg = 4'hF; end
          2: begin bg = 4'h0; fg = 4'h0; end
          3: begin bg = 4'hF; fg = 4'h0; end
          4: begin bg = 4'h0; fg = 4'hF; end
          default: begin bg = 4'($urandom); fg = 4'($urandom); end
        endcase
        set_colors(bg, fg);
      end
      // The receiver holds off for a long stretch so the block backs up its input.
      if (phase == 4) long_hold = 400;
      random_traffic(PHASE_ITEMS);
    end

    wait_all_results();
    repeat (CELLS + 20) @(posedge clk_i);
    screen_state.flush_missing();
    if (screen_state.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
